// ----- rtl/core/ghash_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ghash_pkg;

	// Field element and port widths
	localparam int BLOCK_W = 128;
	localparam int HALF_W  = 64;
	localparam int OUT_W   = 2 * BLOCK_W;

	// Key bits taken per multiply step, and the step count per block
	localparam int DIGIT_W = 4;
	localparam int STEPS   = BLOCK_W / DIGIT_W;
	localparam int CNT_W   = $clog2(STEPS);

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} reg_index_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Reverse the bit order inside every byte
	function automatic logic [HALF_W-1:0] byte_bitrev(input logic [HALF_W-1:0] v);
		logic [HALF_W-1:0] r;
		r = '0;
		for (int b = 0; b < HALF_W / 8; b++) begin
			for (int k = 0; k < 8; k++) begin
				r[8*b + k] = v[8*b + 7 - k];
			end
		end
		return r;
	endfunction

	// One Horner step: z * x^DIGIT_W + s * d, reduced by x^128 + x^7 + x^2 + x + 1
	function automatic logic [BLOCK_W-1:0] gf_digit(
		input logic [BLOCK_W-1:0] z,
		input logic [BLOCK_W-1:0] s,
		input logic [DIGIT_W-1:0] d
	);
		logic [BLOCK_W+DIGIT_W-1:0] t;
		logic [DIGIT_W-1:0]         top;
		logic [BLOCK_W-1:0]         fold;
		t = {z, {DIGIT_W{1'b0}}};
		for (int k = 0; k < DIGIT_W; k++) begin
			if (d[k]) begin
				t = t ^ ({{DIGIT_W{1'b0}}, s} << k);
			end
		end
		top  = t[BLOCK_W+DIGIT_W-1 -: DIGIT_W];
		fold = BLOCK_W'(top) ^ (BLOCK_W'(top) << 1) ^ (BLOCK_W'(top) << 2)
			^ (BLOCK_W'(top) << 7);
		return t[BLOCK_W-1:0] ^ fold;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ghash_multiply_accumulate_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// GHASH multiply-accumulate for GCM over GF(2^128). Each input beat carries one
// 128-bit block; its bytes are bit-reversed, XORed into the accumulator (or into
// zero when the restart flag is set) and the sum is multiplied by the hash key,
// reduced by x^128 + x^7 + x^2 + x + 1. The key is loaded through the cfg port
// (index 0: key words 0 and 1, index 1: key words 2 and 3, byte-bit-reversed
// form) and may only be written while no block is in flight. Each block goes
// through a load step, 32 multiply steps that each shift four key bits out of
// a key shift register into a single shared 128-bit multiply-reduce step, and
// a handoff into the output register. A new block is accepted on the cycle
// after the handoff, even while the previous result still waits in the output
// register.
module ghash_multiply_accumulate_top (
	input  wire                          clk,
	input  wire                          arst_n,
	// cfg port
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire                          cfg_index,
	input  wire  [ghash_pkg::HALF_W-1:0] cfg_data,
	// input stream
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [ghash_pkg::BLOCK_W-1:0] s_tdata,  // data_low, data_high
	input  wire                          s_tuser,   // restart
	// result stream
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [ghash_pkg::OUT_W-1:0]  m_tdata    // acc_low, acc_high, tag_low, tag_high
);
	import ghash_pkg::*;

	state_t                  state_q;
	logic [HALF_W-1:0]       key_low_q;
	logic [HALF_W-1:0]       key_high_q;
	logic [BLOCK_W-1:0]      key_sr_q;
	logic [BLOCK_W-1:0]      sum_q;
	logic [BLOCK_W-1:0]      z_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	logic                    in_beat;
	logic                    out_free;
	logic [BLOCK_W-1:0]      acc_base;
	logic [BLOCK_W-1:0]      sum_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Form the multiplicand: reversed block XOR accumulator, or zero on restart
	assign acc_base = s_tuser ? '0 : z_q;
	assign sum_next = acc_base ^ {byte_bitrev(s_tdata[BLOCK_W-1:HALF_W]),
		byte_bitrev(s_tdata[HALF_W-1:0])};

	// Capture key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequence load, digit steps and handoff; z_q doubles as the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			z_q     <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						z_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					z_q   <= gf_digit(z_q, sum_q, key_sr_q[BLOCK_W-1 -: DIGIT_W]);
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Load the multiplicand and key, then shift key digits out MSB first
	always_ff @(posedge clk) begin
		if (in_beat) begin
			sum_q    <= sum_next;
			key_sr_q <= {key_high_q, key_low_q};
		end else if (state_q == ST_RUN) begin
			key_sr_q <= key_sr_q << DIGIT_W;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {byte_bitrev(z_q[BLOCK_W-1:HALF_W]), byte_bitrev(z_q[HALF_W-1:0]),
				z_q};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ghash_mac_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ghash_mac_chk (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          cfg_valid,
	input wire                          cfg_ready,
	input wire                          s_tvalid,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire  [ghash_pkg::OUT_W-1:0]  m_tdata
);
	import ghash_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Tag halves are the byte-bit-reversed accumulator halves
	a_tag_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3*HALF_W-1:2*HALF_W] == byte_bitrev(m_tdata[HALF_W-1:0]))
			&& (m_tdata[4*HALF_W-1:3*HALF_W] == byte_bitrev(m_tdata[2*HALF_W-1:HALF_W])))
		else $error("tag does not match accumulator");

	// One block at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a block while busy");

	// Key writes are never stalled
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write stalled");

endmodule

bind ghash_multiply_accumulate_top ghash_mac_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

`default_nettype wire
